// ----- src/mra_pkg.sv -----
// Shared types and constants for the mapped-region allocator.
package mra_pkg;

    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 40;

    localparam logic [31:0] BASE_RESET = 32'h6000_0000;
    localparam logic [31:0] TOP_RESET  = 32'h8000_0000;

    // configuration register indexes
    localparam logic CFG_BASE = 1'b0;
    localparam logic CFG_TOP  = 1'b1;

    // request opcodes
    localparam logic OP_MAP   = 1'b0;
    localparam logic OP_UNMAP = 1'b1;

    typedef struct packed {
        logic        opcode;
        logic [31:0] address;
        logic [30:0] length;
        logic        fixed;
        logic        grows_up;
        logic        private_map;
        logic        shared_map;
        logic        anonymous;
        logic        file_present;
    } t_req;

    typedef struct packed {
        logic        ok;
        logic [31:0] region_start;
        logic [3:0]  slot_used;
    } t_result;

    // table write commands
    typedef struct packed {
        logic set;
        logic clr;
    } t_tbl_cmd;

    // kind of range test applied during a table scan
    typedef enum logic [1:0] {
        SCAN_UNMAP  = 2'd0,
        SCAN_FIXED  = 2'd1,
        SCAN_SEARCH = 2'd2
    } t_scan;

endpackage

// ----- src/mra_table.sv -----
// Region table: valid flops plus start/end memory with one registered read port.
module mra_table
    import mra_pkg::*;
#(
    parameter int SLOTS = 16,
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_tbl_cmd          i_cmd,
    input  logic [IDX_W-1:0]  i_wr_addr,
    input  logic [31:0]       i_wr_start,
    input  logic [31:0]       i_wr_end,
    input  logic [IDX_W-1:0]  i_rd_addr,
    output logic              o_rd_valid,
    output logic [31:0]       o_rd_start,
    output logic [31:0]       o_rd_end
);

    logic [SLOTS-1:0] r_valid;
    logic [31:0]      r_mem_start [SLOTS];
    logic [31:0]      r_mem_end   [SLOTS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.set) begin
            r_valid[i_wr_addr] <= 1'b1;
        end else if (i_cmd.clr) begin
            r_valid[i_wr_addr] <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.set) begin
            r_mem_start[i_wr_addr] <= i_wr_start;
            r_mem_end[i_wr_addr]   <= i_wr_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_rd_valid <= 1'b0;
        end else begin
            o_rd_valid <= r_valid[i_rd_addr];
        end
        o_rd_start <= r_mem_start[i_rd_addr];
        o_rd_end   <= r_mem_end[i_rd_addr];
    end

endmodule

// ----- src/mra_cmp.sv -----
// Shared range compare unit applied to one table entry per scan step.
module mra_cmp
    import mra_pkg::*;
(
    input  t_scan        i_kind,
    input  logic         i_valid,
    input  logic [31:0]  i_start,
    input  logic [31:0]  i_end,
    input  logic [31:0]  i_a,
    input  logic [31:0]  i_e,
    output logic         o_hit
);

    logic start_in;
    logic end_in;
    logic covers;
    logic contains;

    always_comb begin
        start_in = (i_start >= i_a) && (i_start < i_e);
        end_in   = (i_end > i_a) && (i_end <= i_e);
        covers   = (i_start <= i_a) && (i_end > i_e);
        contains = (i_start <= i_a) && (i_end > i_a);
        unique case (i_kind)
            SCAN_UNMAP:  o_hit = i_valid && contains;
            SCAN_FIXED:  o_hit = i_valid && (start_in || end_in || covers);
            SCAN_SEARCH: o_hit = i_valid && start_in;
            default:     o_hit = 1'b0;
        endcase
    end

endmodule

// ----- src/mra_seq.sv -----
// Request sequencer: drives the table scans, end rounding and result.
module mra_seq
    import mra_pkg::*;
#(
    parameter int SLOTS      = 16,
    parameter int PAGE_BYTES = 4096,
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1,
    localparam int TRY_W = $clog2(SLOTS + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  t_req              i_req,
    input  logic [31:0]       i_base,
    input  logic [31:0]       i_top,
    input  logic              i_out_free,
    output logic              o_done,
    output t_result           o_res
);

    localparam logic [31:0]      PG_MASK  = 32'(PAGE_BYTES - 1);
    localparam logic [31:0]      PG_GROW  = 32'(2 * PAGE_BYTES - 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);
    localparam logic [TRY_W-1:0] MAX_TRY  = TRY_W'(SLOTS);

    typedef enum logic [12:0] {
        S_IDLE     = 13'b0000000000001,
        S_PRE      = 13'b0000000000010,
        S_FREE_RD  = 13'b0000000000100,
        S_FREE_CMP = 13'b0000000001000,
        S_FIX_CHK  = 13'b0000000010000,
        S_SUM      = 13'b0000000100000,
        S_ROUND    = 13'b0000001000000,
        S_END_CHK  = 13'b0000010000000,
        S_SCAN_RD  = 13'b0000100000000,
        S_SCAN_CMP = 13'b0001000000000,
        S_CLEAR    = 13'b0010000000000,
        S_WRITE    = 13'b0100000000000,
        S_DONE     = 13'b1000000000000
    } t_state;

    t_state            r_state, n_state;
    t_req              r_req, n_req;
    logic [31:0]       r_a, n_a;
    logic [31:0]       r_e, n_e;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [IDX_W-1:0]  r_slot, n_slot;
    logic [TRY_W-1:0]  r_tries, n_tries;
    logic              r_ok, n_ok;

    t_scan             kind;
    t_tbl_cmd          tbl_cmd;
    logic              rd_valid;
    logic [31:0]       rd_start;
    logic [31:0]       rd_end;
    logic              hit;
    logic [IDX_W+3:0]  slot_ext;

    assign kind = (r_req.opcode == OP_UNMAP) ? SCAN_UNMAP :
                  (r_req.fixed ? SCAN_FIXED : SCAN_SEARCH);

    assign tbl_cmd.set = (r_state == S_WRITE);
    assign tbl_cmd.clr = (r_state == S_CLEAR);

    mra_table #(.SLOTS(SLOTS)) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (tbl_cmd),
        .i_wr_addr  (r_slot),
        .i_wr_start (r_a),
        .i_wr_end   (r_e),
        .i_rd_addr  (r_idx),
        .o_rd_valid (rd_valid),
        .o_rd_start (rd_start),
        .o_rd_end   (rd_end)
    );

    mra_cmp u_cmp (
        .i_kind  (kind),
        .i_valid (rd_valid),
        .i_start (rd_start),
        .i_end   (rd_end),
        .i_a     (r_a),
        .i_e     (r_e),
        .o_hit   (hit)
    );

    always_comb begin
        n_state = r_state;
        n_req   = r_req;
        n_a     = r_a;
        n_e     = r_e;
        n_idx   = r_idx;
        n_slot  = r_slot;
        n_tries = r_tries;
        n_ok    = r_ok;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_req   = i_req;
                    n_state = S_PRE;
                end
            end
            S_PRE: begin
                n_idx   = '0;
                n_tries = '0;
                n_a     = r_req.address;
                n_ok    = 1'b0;
                if (r_req.opcode == OP_UNMAP) begin
                    if (r_req.length == '0 || r_req.address < i_base ||
                        r_req.address >= i_top) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_SCAN_RD;
                    end
                end else if (r_req.length == '0 ||
                             r_req.private_map == r_req.shared_map ||
                             (!r_req.anonymous && !r_req.file_present)) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_FREE_RD;
                end
            end
            S_FREE_RD: begin
                n_state = S_FREE_CMP;
            end
            S_FREE_CMP: begin
                if (!rd_valid) begin
                    n_slot = r_idx;
                    if (r_req.fixed) begin
                        n_state = S_FIX_CHK;
                    end else begin
                        n_a     = i_base;
                        n_state = S_SUM;
                    end
                end else if (r_idx == LAST_IDX) begin
                    n_state = S_DONE;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_FREE_RD;
                end
            end
            S_FIX_CHK: begin
                if (i_base > r_a || i_top <= r_a) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_SUM;
                end
            end
            S_SUM: begin
                n_e     = r_a + {1'b0, r_req.length};
                n_state = S_ROUND;
            end
            S_ROUND: begin
                // round up to a page; the guard page folds into the same add
                n_e     = (r_e + (r_req.grows_up ? PG_GROW : PG_MASK)) & ~PG_MASK;
                n_state = S_END_CHK;
            end
            S_END_CHK: begin
                n_idx = '0;
                if (r_e >= i_top) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_SCAN_RD;
                end
            end
            S_SCAN_RD: begin
                n_state = S_SCAN_CMP;
            end
            S_SCAN_CMP: begin
                if (hit) begin
                    unique case (kind)
                        SCAN_UNMAP: begin
                            n_slot  = r_idx;
                            n_state = S_CLEAR;
                        end
                        SCAN_SEARCH: begin
                            if (r_tries == MAX_TRY) begin
                                n_state = S_DONE;
                            end else begin
                                // move the candidate past the blocking region
                                n_tries = r_tries + 1'b1;
                                n_a     = rd_end;
                                n_state = S_SUM;
                            end
                        end
                        default: n_state = S_DONE;
                    endcase
                end else if (r_idx == LAST_IDX) begin
                    n_state = (kind == SCAN_UNMAP) ? S_DONE : S_WRITE;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_SCAN_RD;
                end
            end
            S_CLEAR: begin
                n_ok    = 1'b1;
                n_state = S_DONE;
            end
            S_WRITE: begin
                n_ok    = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ok    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ok    <= n_ok;
        end
        r_req   <= n_req;
        r_a     <= n_a;
        r_e     <= n_e;
        r_idx   <= n_idx;
        r_slot  <= n_slot;
        r_tries <= n_tries;
    end

    assign slot_ext = {4'b0, r_slot};

    assign o_ready             = (r_state == S_IDLE);
    assign o_done              = (r_state == S_DONE) && i_out_free;
    assign o_res.ok            = r_ok;
    assign o_res.region_start  = (r_ok && r_req.opcode == OP_MAP) ? r_a : 32'd0;
    assign o_res.slot_used     = r_ok ? slot_ext[3:0] : 4'd0;

endmodule

// ----- src/mmap_region_allocator_top.sv -----
// Top level of the mapped-region allocator: ports, configuration and result register.
//
// Requests enter on the s_axis channel, one transaction per map or unmap request;
// every request yields exactly one result transaction on m_axis (tuser = ok).
// region_base and region_top are written through the cfg channel (index 0 and 1),
// which is always ready and must only be used while no request is in flight.
// A request is processed by one sequencer that walks the slot table through a
// single registered read port and one shared compare unit, with a read state and
// a compare state per slot. An unmap scans up to the first matching slot; a map
// first looks for a free slot, then scans the table for a conflict, and each
// candidate move of a search request repeats that scan, up to SLOTS moves.
// s_axis_tready is high only while the sequencer is idle: one request at a time.
// The result waits in an output register; while the receiver stalls, the next
// request is accepted and runs up to its result, which then waits for the slot.
// Reset (synchronous, active low) empties the table, restores both limits and
// drops any pending result.
module mmap_region_allocator_top
    import mra_pkg::*;
#(
    parameter int SLOTS      = 16,
    parameter int PAGE_BYTES = 4096
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // address[31:0], length[62:32], fixed[63], grows_up[64], private_map[65],
    // shared_map[66], anonymous[67], file_present[68], zero[71:69]
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // opcode[0]
    input  logic                   s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // region_start[31:0], slot_used[35:32], zero[39:36]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // ok[0]
    output logic                   m_axis_tuser,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic                   i_cfg_addr,
    input  logic [31:0]            i_cfg_data
);

    logic [31:0] r_base;
    logic [31:0] r_top;
    logic        r_out_valid;
    t_result     r_out;

    t_req        req;
    t_result     res;
    logic        done;
    logic        out_free;

    assign req.opcode       = s_axis_tuser;
    assign req.address      = s_axis_tdata[31:0];
    assign req.length       = s_axis_tdata[62:32];
    assign req.fixed        = s_axis_tdata[63];
    assign req.grows_up     = s_axis_tdata[64];
    assign req.private_map  = s_axis_tdata[65];
    assign req.shared_map   = s_axis_tdata[66];
    assign req.anonymous    = s_axis_tdata[67];
    assign req.file_present = s_axis_tdata[68];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= BASE_RESET;
            r_top  <= TOP_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_addr)
                CFG_BASE: r_base <= i_cfg_data;
                CFG_TOP:  r_top  <= i_cfg_data;
                default:  r_base <= r_base;
            endcase
        end
    end

    assign out_free = !r_out_valid || m_axis_tready;

    mra_seq #(
        .SLOTS      (SLOTS),
        .PAGE_BYTES (PAGE_BYTES)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_req      (req),
        .i_base     (r_base),
        .i_top      (r_top),
        .i_out_free (out_free),
        .o_done     (done),
        .o_res      (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (done) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (done) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.ok;
    assign m_axis_tdata  = {4'b0, r_out.slot_used, r_out.region_start};

endmodule

// ----- src/mra_checker.sv -----
// Port-level checks for the mapped-region allocator, bound to the top level.
module mra_checker
    import mra_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                   m_axis_tuser
);

    // one request at a time: busy right after a transaction
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input taken while a request is in flight");

    // a result never shows up the cycle right after its request
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tvalid && s_axis_tready))
        else $error("result appeared too early");

    // a failed request reports no address and no slot
    a_fail_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("failed result carries data");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled result changed");

endmodule

bind mmap_region_allocator_top mra_checker u_mra_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ----- bench/mmap_region_allocator_top_test.sv -----
// Self-checking testbench for the mapped-region allocator: directed and random requests.
module mmap_region_allocator_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import mra_pkg::*;

    localparam int          SLOTS       = 16;
    localparam logic [31:0] PAGE        = 32'd4096;
    // worst search: 16 candidate moves on top of the slot scans
    localparam int          MAX_LATENCY = 700;
    // several times the slowest run: every request a full search behind a stalled receiver
    localparam int unsigned CYCLE_LIMIT = 2_000_000;
    localparam int          BATCH_ITEMS = 60;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idling;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   s_axis_tuser = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tuser;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic                   i_cfg_addr = CFG_BASE;
    logic [31:0]            i_cfg_data = '0;

    // predicted region table and limits
    logic        tbl_valid [SLOTS] = '{default: 1'b0};
    logic [31:0] tbl_start [SLOTS] = '{default: 32'd0};
    logic [31:0] tbl_end   [SLOTS] = '{default: 32'd0};
    logic [31:0] lim_base = BASE_RESET;
    logic [31:0] lim_top  = TOP_RESET;

    t_result     pending_outcomes[$];
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          mismatches     = 0;
    int          n_map_reqs     = 0;
    int          n_unmap_reqs   = 0;
    int          n_granted      = 0;
    int          n_refused      = 0;
    int unsigned cycle_count    = 0;

    mmap_region_allocator_top DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_data   (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("mmap_region_allocator_top test failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic logic [31:0] page_round(input logic [31:0] x);
        logic [31:0] s;
        s = x + (PAGE - 32'd1);
        return s & ~(PAGE - 32'd1);
    endfunction

    function automatic logic [31:0] region_end(input logic [31:0] start, input logic [30:0] len,
                                               input logic grow);
        logic [31:0] e;
        e = page_round(start + {1'b0, len});
        if (grow) begin
            e = e + PAGE;
        end
        return e;
    endfunction

    // Work out the outcome of one request and update the predicted table.
    function automatic t_result allocate_or_release(input t_req r);
        t_result     res;
        int          k, free_slot, hit, tries;
        logic [31:0] cand, stop;
        logic        found;
        res = '0;
        free_slot = -1;
        found = 1'b0;
        if (r.opcode == OP_UNMAP) begin
            if (r.length == 0 || r.address < lim_base || r.address >= lim_top) begin
                return res;
            end
            for (k = 0; k < SLOTS; k++) begin
                if (tbl_valid[k] && tbl_start[k] <= r.address && tbl_end[k] > r.address) begin
                    tbl_valid[k] = 1'b0;
                    tbl_start[k] = '0;
                    tbl_end[k] = '0;
                    res.ok = 1'b1;
                    res.slot_used = 4'(k);
                    return res;
                end
            end
            return res;
        end
        if (r.length == 0 || r.private_map == r.shared_map || (!r.anonymous && !r.file_present)) begin
            return res;
        end
        for (k = SLOTS - 1; k >= 0; k--) begin
            if (!tbl_valid[k]) begin
                free_slot = k;
            end
        end
        if (free_slot < 0) begin
            return res;
        end
        if (r.fixed) begin
            cand = r.address;
            if (lim_base > cand || lim_top <= cand) begin
                return res;
            end
            stop = region_end(cand, r.length, r.grows_up);
            if (lim_top <= stop) begin
                return res;
            end
            for (k = 0; k < SLOTS; k++) begin
                if (tbl_valid[k] &&
                    ((tbl_start[k] >= cand && tbl_start[k] < stop) ||
                     (tbl_end[k] > cand && tbl_end[k] <= stop) ||
                     (tbl_start[k] <= cand && tbl_end[k] > stop))) begin
                    return res;
                end
            end
            found = 1'b1;
        end else begin
            cand = lim_base;
            stop = region_end(cand, r.length, r.grows_up);
            // bounded so that a chain of wrapped regions cannot loop forever
            for (tries = 0; tries <= SLOTS; tries++) begin
                if (stop >= lim_top) begin
                    break;
                end
                hit = -1;
                for (k = 0; k < SLOTS && hit < 0; k++) begin
                    if (tbl_valid[k] && tbl_start[k] >= cand && tbl_start[k] < stop) begin
                        hit = k;
                    end
                end
                if (hit < 0) begin
                    found = 1'b1;
                    break;
                end
                cand = tbl_end[hit];
                stop = region_end(cand, r.length, r.grows_up);
            end
        end
        if (!found) begin
            return res;
        end
        tbl_valid[free_slot] = 1'b1;
        tbl_start[free_slot] = cand;
        tbl_end[free_slot] = stop;
        res.ok = 1'b1;
        res.region_start = cand;
        res.slot_used = 4'(free_slot);
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        if (mismatches <= 40) begin
            $display("mismatch at cycle %0d: %s got %h expected %h", cycle_count, what, got, want);
        end
    endtask

    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_outcomes.size() == 0) begin
                report_mismatch("unexpected result", m_axis_tdata[31:0], '0);
            end else begin
                want = pending_outcomes.pop_front();
                if (m_axis_tuser !== want.ok) begin
                    report_mismatch("ok", 32'(m_axis_tuser), 32'(want.ok));
                end
                if (m_axis_tdata[31:0] !== want.region_start) begin
                    report_mismatch("region_start", m_axis_tdata[31:0], want.region_start);
                end
                if (m_axis_tdata[35:32] !== want.slot_used) begin
                    report_mismatch("slot_used", 32'(m_axis_tdata[35:32]), 32'(want.slot_used));
                end
                if (want.ok) begin
                    n_granted++;
                end else begin
                    n_refused++;
                end
            end
        end
    end

    task automatic set_idling(input t_idling mode);
        case (mode)
            IDLE_NONE: begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
            IDLE_SEND: begin
                send_idle_pct = 69;
                recv_stall_pct = 0;
            end
            IDLE_RECV: begin
                send_idle_pct = 0;
                recv_stall_pct = 69;
            end
            default: begin
                send_idle_pct = 31;
                recv_stall_pct = 31;
            end
        endcase
    endtask

    // Send one request transaction and queue its predicted outcome.
    task automatic send_request(input t_req r);
        int gap;
        gap = 0;
        while (gap < 30 && $urandom_range(99) < send_idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {3'b000, r.file_present, r.anonymous, r.shared_map, r.private_map,
                         r.grows_up, r.fixed, r.length, r.address};
        s_axis_tuser <= r.opcode;
        do @(posedge i_clk); while (!s_axis_tready);
        pending_outcomes.push_back(allocate_or_release(r));
        if (r.opcode == OP_MAP) begin
            n_map_reqs++;
        end else begin
            n_unmap_reqs++;
        end
    endtask

    // Hold the sender until every queued outcome has been seen.
    task automatic wait_results_done();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_outcomes.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_limits(input logic [31:0] base_v, input logic [31:0] top_v);
        i_cfg_valid <= 1'b1;
        i_cfg_addr <= CFG_BASE;
        i_cfg_data <= base_v;
        do @(posedge i_clk); while (!o_cfg_ready);
        lim_base = base_v;
        i_cfg_addr <= CFG_TOP;
        i_cfg_data <= top_v;
        do @(posedge i_clk); while (!o_cfg_ready);
        lim_top = top_v;
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_req map_req(input logic [31:0] addr, input logic [30:0] len,
                                     input logic fix, input logic grow);
        t_req r;
        r = '0;
        r.opcode = OP_MAP;
        r.address = addr;
        r.length = len;
        r.fixed = fix;
        r.grows_up = grow;
        r.private_map = 1'b1;
        r.anonymous = 1'b1;
        return r;
    endfunction

    function automatic t_req unmap_req(input logic [31:0] addr, input logic [30:0] len);
        t_req r;
        r = '0;
        r.opcode = OP_UNMAP;
        r.address = addr;
        r.length = len;
        return r;
    endfunction

    // Mostly well-formed maps and unmaps of live regions, with some noise.
    function automatic t_req random_request();
        t_req        r;
        int          pick, s;
        int          live[$];
        logic [31:0] win;
        r = '0;
        for (s = 0; s < SLOTS; s++) begin
            if (tbl_valid[s] && tbl_end[s] > tbl_start[s]) begin
                live.push_back(s);
            end
        end
        pick = $urandom_range(99);
        if (pick < 12) begin
            r.opcode = 1'($urandom_range(1));
            r.address = $urandom;
            r.length = 31'($urandom);
            r.fixed = 1'($urandom_range(1));
            r.grows_up = 1'($urandom_range(1));
            r.private_map = 1'($urandom_range(1));
            r.shared_map = 1'($urandom_range(1));
            r.anonymous = 1'($urandom_range(1));
            r.file_present = 1'($urandom_range(1));
        end else if (pick < 40 && live.size() > 0) begin
            s = live[$urandom_range(live.size() - 1)];
            r.opcode = OP_UNMAP;
            r.address = tbl_start[s] + ($urandom % (tbl_end[s] - tbl_start[s]));
            r.length = 31'($urandom_range(1, 8192));
        end else begin
            r.opcode = OP_MAP;
            r.private_map = 1'($urandom_range(1));
            r.shared_map = !r.private_map;
            case ($urandom_range(2))
                0: r.anonymous = 1'b1;
                1: r.file_present = 1'b1;
                default: begin
                    r.anonymous = 1'b1;
                    r.file_present = 1'b1;
                end
            endcase
            r.grows_up = ($urandom_range(99) < 30);
            pick = $urandom_range(99);
            if (pick < 70) begin
                r.length = 31'($urandom_range(1, 16384));
            end else if (pick < 88) begin
                r.length = 31'($urandom_range(1, 1 << 20));
            end else if (pick < 97) begin
                r.length = 31'($urandom);
            end
            r.fixed = ($urandom_range(99) < 35);
            win = lim_top - lim_base;
            if (r.fixed && live.size() > 0 && $urandom_range(1)) begin
                // land near a live region to provoke overlaps
                s = live[$urandom_range(live.size() - 1)];
                r.address = tbl_start[s] + ($urandom_range(8) * 32'h800) - 32'h1000;
            end else begin
                r.address = lim_base + ((win == 0) ? $urandom : ($urandom % win));
                if ($urandom_range(99) < 75) begin
                    r.address[11:0] = '0;
                end
            end
        end
        return r;
    endfunction

    // Unmap every region that can be reached under the current limits.
    task automatic clear_table();
        int          s;
        logic [31:0] starts[$];
        for (s = 0; s < SLOTS; s++) begin
            if (tbl_valid[s] && tbl_end[s] > tbl_start[s] &&
                tbl_start[s] >= lim_base && tbl_start[s] < lim_top) begin
                starts.push_back(tbl_start[s]);
            end
        end
        foreach (starts[j]) begin
            send_request(unmap_req(starts[j], 31'd1));
        end
    endtask

    task automatic test_map_rejects();
        t_req r;
        send_request(map_req(32'h6000_0000, 31'd0, 1'b0, 1'b0));
        r = map_req(32'h6000_0000, 31'h1000, 1'b0, 1'b0);
        r.shared_map = 1'b1;
        send_request(r);
        r.private_map = 1'b0;
        r.shared_map = 1'b0;
        send_request(r);
        r = map_req(32'h6000_0000, 31'h1000, 1'b0, 1'b0);
        r.anonymous = 1'b0;
        send_request(r);
    endtask

    task automatic test_placement();
        t_req r;
        send_request(map_req(32'h0, 31'd1, 1'b0, 1'b0));
        send_request(map_req(32'h0, 31'h1001, 1'b0, 1'b1));
        r = map_req(32'h0, 31'h800, 1'b0, 1'b0);
        r.anonymous = 1'b0;
        r.file_present = 1'b1;
        r.private_map = 1'b0;
        r.shared_map = 1'b1;
        send_request(r);
        send_request(map_req(32'h0, 31'h7FFF_FFFF, 1'b0, 1'b1));
        send_request(map_req(32'h5FFF_F000, 31'h1000, 1'b1, 1'b0));
        send_request(map_req(32'h8000_0000, 31'h1000, 1'b1, 1'b0));
        send_request(map_req(32'h7FFF_F000, 31'h1000, 1'b1, 1'b0));
        send_request(map_req(32'h7000_0000, 31'h2000, 1'b1, 1'b0));
        // overlaps: same end, enclosing, enclosed
        send_request(map_req(32'h7000_1000, 31'h1000, 1'b1, 1'b0));
        send_request(map_req(32'h6FFF_F000, 31'h4000, 1'b1, 1'b0));
        send_request(map_req(32'h7000_0800, 31'd1, 1'b1, 1'b0));
        send_request(map_req(32'hFFFF_FFFF, 31'h7FFF_FFFF, 1'b1, 1'b1));
    endtask

    task automatic test_unmap_cases();
        send_request(unmap_req(32'h7000_0000, 31'd0));
        send_request(unmap_req(32'h5FFF_FFFF, 31'd1));
        send_request(unmap_req(32'h8000_0000, 31'd1));
        send_request(unmap_req(32'h7F00_0000, 31'd1));
        send_request(unmap_req(32'h7000_1FFF, 31'h7FFF_FFFF));
        send_request(unmap_req(32'hFFFF_FFFF, 31'd1));
        send_request(unmap_req(32'h6000_0000, 31'd1));
    endtask

    task automatic test_table_full();
        int n;
        wait_results_done();
        for (n = 0; n <= SLOTS; n++) begin
            send_request(map_req(32'h0, 31'h1000, 1'b0, 1'b0));
        end
        clear_table();
        wait_results_done();
    endtask

    // Three regions that chain back onto each other across the 32-bit wrap,
    // so a search from the base runs out of candidates.
    task automatic test_wrapped_cycle();
        write_limits(32'h0000_1000, 32'hFFFF_FFFF);
        send_request(map_req(32'hFFFF_E000, 31'h3000, 1'b1, 1'b0));
        send_request(map_req(32'h0000_1000, 31'h7FFF_F000, 1'b1, 1'b0));
        send_request(map_req(32'h8000_0000, 31'h7FFF_E000, 1'b1, 1'b0));
        wait_results_done();
        write_limits(32'hFFFF_E000, 32'hFFFF_FFFF);
        send_request(map_req(32'h0, 31'd1, 1'b0, 1'b0));
        wait_results_done();
        write_limits(32'h0000_1000, 32'hFFFF_FFFF);
        clear_table();
        wait_results_done();
    endtask

    task automatic test_random_traffic();
        logic [31:0] bases [8] = '{BASE_RESET, 32'h0000_0000, 32'h6000_0000, 32'hFFFF_0000,
                                   32'h4000_0000, 32'hFFFF_FFFF, 32'h1000_0000, BASE_RESET};
        logic [31:0] tops  [8] = '{TOP_RESET, 32'hFFFF_FFFF, 32'h6004_0000, 32'hFFFF_FFFF,
                                   32'h4001_0000, 32'h0000_0000, 32'h1020_0000, TOP_RESET};
        int b, n;
        for (b = 0; b < 8; b++) begin
            wait_results_done();
            clear_table();
            wait_results_done();
            write_limits(bases[b], tops[b]);
            set_idling(t_idling'(b % 4));
            for (n = 0; n < BATCH_ITEMS; n++) begin
                if (n == BATCH_ITEMS / 2) begin
                    wait_results_done();
                end
                send_request(random_request());
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_map_rejects();
        test_placement();
        test_unmap_cases();
        test_table_full();
        test_wrapped_cycle();
        test_random_traffic();
        wait_results_done();
        repeat (MAX_LATENCY) @(posedge i_clk);
        $display("covered %0d map and %0d unmap requests: %0d granted, %0d refused",
                 n_map_reqs, n_unmap_reqs, n_granted, n_refused);
        $display("limits swept from empty windows to the full 32-bit space, %0d mismatches",
                 mismatches);
        if (mismatches == 0 && pending_outcomes.size() == 0) begin
            $display("mmap_region_allocator_top test passed");
        end else begin
            $display("mmap_region_allocator_top test failed");
        end
        $finish;
    end

endmodule
